>>> src/tmma_pkg.sv
package tmma_pkg;

    localparam int GROUP_SAMPLES = 16;
    localparam int WINDOW        = 10;

    localparam int SAMPLE_W   = 12;
    localparam int PCT_W      = 7;
    localparam int FULL_SCALE = 4095;
    localparam int PCT_SCALE  = 100;
    localparam int TRIM_DIV   = (GROUP_SAMPLES > 2) ? GROUP_SAMPLES - 2 : GROUP_SAMPLES;

    localparam int POS_W  = $clog2(GROUP_SAMPLES);
    localparam int GSUM_W = $clog2(GROUP_SAMPLES * FULL_SCALE + 1);
    localparam int WSUM_W = $clog2(WINDOW * FULL_SCALE + 1);
    localparam int WIN_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);

    // trimmed mean by reciprocal multiplication, exact for every trimmed group sum
    localparam int TRIM_SHIFT = 22;
    localparam int TRIM_RECIP = ((1 << TRIM_SHIFT) + TRIM_DIV - 1) / TRIM_DIV;
    localparam int TRIM_RW    = $clog2(TRIM_RECIP + 1);
    localparam int MEAN_PW    = GSUM_W + TRIM_RW;

    // level times percent scale
    localparam int PCTX_W = SAMPLE_W + PCT_W;

    // divider: window sum over fill count
    localparam int DIV_NW = WSUM_W;
    localparam int DIV_DW = FILL_W;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

endpackage

>>> src/tmma_ram.sv
module tmma_ram #(
    parameter int DEPTH = 10,
    parameter int WIDTH = 12,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/tmma_div.sv
module tmma_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tmma_pkg::div_req_t req,
    output tmma_pkg::div_rsp_t rsp
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [tmma_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic [tmma_pkg::DIV_NW-1:0] quo_reg, quo_next;
    logic [tmma_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [tmma_pkg::DIV_DW-1:0] dsr_reg, dsr_next;
    logic [tmma_pkg::DIV_DW:0]   rem_shift;
    logic [tmma_pkg::DIV_DW:0]   rem_sub;
    logic                        fits;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg, quo_reg[tmma_pkg::DIV_NW-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[tmma_pkg::DIV_NW-2:0], fits};
            rem_next = fits ? rem_sub[tmma_pkg::DIV_DW-1:0]
                            : rem_shift[tmma_pkg::DIV_DW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tmma_pkg::DIV_CW'(tmma_pkg::DIV_NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> src/trimmed_mean_moving_average_core.sv
// a sample inside a group is taken without closing the input: s_tready stays high
// throughput within a group: one sample per cycle
// the last sample of a group yields its result through these steps in order:
// trimmed mean and ring update, the 16-step window divide, then percent and output
// s_tready stays low through those steps, longer while the previous result still waits
// reset (aresetn low, synchronous) empties the group and the window; ring ram is not swept
module trimmed_mean_moving_average_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tmma_pkg::S_TDATA_W-1:0] s_tdata,  // [11:0] sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tmma_pkg::M_TDATA_W-1:0] m_tdata   // [11:0] group_mean, [23:12] filtered_level,
                                                     // [30:24] level_percent
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_MEAN_WAIT,
        S_LEVEL,
        S_LEVEL_WAIT,
        S_PCT,
        S_OUT
    } state_t;

    state_t                        state_reg, state_next;
    logic [tmma_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [tmma_pkg::GSUM_W-1:0]   gsum_reg, gsum_next;
    logic [tmma_pkg::SAMPLE_W-1:0] gmin_reg, gmin_next;
    logic [tmma_pkg::SAMPLE_W-1:0] gmax_reg, gmax_next;
    logic [tmma_pkg::WIN_AW-1:0]   slot_reg, slot_next;
    logic [tmma_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [tmma_pkg::WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [tmma_pkg::SAMPLE_W-1:0] mean_reg, mean_next;
    logic [tmma_pkg::SAMPLE_W-1:0] level_reg, level_next;
    logic [tmma_pkg::PCT_W-1:0]    pct_reg, pct_next;
    logic                          mvalid_reg, mvalid_next;
    logic [tmma_pkg::M_TDATA_W-1:0] mdata_reg, mdata_next;

    logic [tmma_pkg::SAMPLE_W-1:0] sample;
    logic                          s_accept;
    logic [tmma_pkg::GSUM_W-1:0]   rest;
    logic [tmma_pkg::MEAN_PW-1:0]  mean_prod;
    logic [tmma_pkg::PCTX_W-1:0]   pct_prod;
    logic [tmma_pkg::PCTX_W-1:0]   pct_sum;
    logic [tmma_pkg::SAMPLE_W-1:0] old_entry;
    logic [tmma_pkg::SAMPLE_W-1:0] ram_rdata;
    logic                          ram_wr_en;
    logic                          ram_rd_en;
    tmma_pkg::div_req_t            div_req;
    tmma_pkg::div_rsp_t            div_rsp;

    assign sample   = s_tdata[tmma_pkg::SAMPLE_W-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign rest = (tmma_pkg::GROUP_SAMPLES > 2)
                ? gsum_reg - tmma_pkg::GSUM_W'(gmin_reg) - tmma_pkg::GSUM_W'(gmax_reg)
                : gsum_reg;

    assign mean_prod = tmma_pkg::MEAN_PW'(rest) * tmma_pkg::MEAN_PW'(tmma_pkg::TRIM_RECIP);

    // divide by 4095 as (x + x/4096 + 1) / 4096
    assign pct_prod = tmma_pkg::PCTX_W'(level_reg) * tmma_pkg::PCTX_W'(tmma_pkg::PCT_SCALE);
    assign pct_sum  = pct_prod + (pct_prod >> tmma_pkg::SAMPLE_W) + tmma_pkg::PCTX_W'(1);

    // ring entries at or beyond the fill count were never written and read as zero
    assign old_entry = (tmma_pkg::WIN_AW'(0) == slot_reg
                        ? fill_reg != '0
                        : tmma_pkg::FILL_W'(slot_reg) < fill_reg) ? ram_rdata : '0;

    assign ram_rd_en = (state_reg == S_MEAN);
    assign ram_wr_en = (state_reg == S_MEAN_WAIT);

    tmma_ram #(
        .DEPTH (tmma_pkg::WINDOW),
        .WIDTH (tmma_pkg::SAMPLE_W),
        .AW    (tmma_pkg::WIN_AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (mean_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    tmma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            S_LEVEL: begin
                div_req.start    = 1'b1;
                div_req.dividend = tmma_pkg::DIV_NW'(wsum_reg);
                div_req.divisor  = tmma_pkg::DIV_DW'(fill_reg);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        gsum_next   = gsum_reg;
        gmin_next   = gmin_reg;
        gmax_next   = gmax_reg;
        slot_next   = slot_reg;
        fill_next   = fill_reg;
        wsum_next   = wsum_reg;
        mean_next   = mean_reg;
        level_next  = level_reg;
        pct_next    = pct_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (pos_reg == '0) begin
                        gsum_next = tmma_pkg::GSUM_W'(sample);
                        gmin_next = sample;
                        gmax_next = sample;
                    end else begin
                        gsum_next = gsum_reg + tmma_pkg::GSUM_W'(sample);
                        if (sample < gmin_reg) begin
                            gmin_next = sample;
                        end
                        if (sample > gmax_reg) begin
                            gmax_next = sample;
                        end
                    end
                    if (pos_reg == tmma_pkg::POS_W'(tmma_pkg::GROUP_SAMPLES - 1)) begin
                        pos_next   = '0;
                        state_next = S_MEAN;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            S_MEAN: begin
                mean_next  = mean_prod[tmma_pkg::TRIM_SHIFT +: tmma_pkg::SAMPLE_W];
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                wsum_next = wsum_reg - tmma_pkg::WSUM_W'(old_entry)
                          + tmma_pkg::WSUM_W'(mean_reg);
                if (slot_reg == tmma_pkg::WIN_AW'(tmma_pkg::WINDOW - 1)) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
                if (fill_reg != tmma_pkg::FILL_W'(tmma_pkg::WINDOW)) begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = S_LEVEL;
            end
            S_LEVEL: begin
                state_next = S_LEVEL_WAIT;
            end
            S_LEVEL_WAIT: begin
                if (div_rsp.done) begin
                    level_next = div_rsp.quotient[tmma_pkg::SAMPLE_W-1:0];
                    state_next = S_PCT;
                end
            end
            S_PCT: begin
                pct_next   = pct_sum[tmma_pkg::SAMPLE_W +: tmma_pkg::PCT_W];
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = tmma_pkg::M_TDATA_W'({pct_reg, level_reg, mean_reg});
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            gsum_reg   <= '0;
            gmin_reg   <= '0;
            gmax_reg   <= '0;
            slot_reg   <= '0;
            fill_reg   <= '0;
            wsum_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            gsum_reg   <= gsum_next;
            gmin_reg   <= gmin_next;
            gmax_reg   <= gmax_next;
            slot_reg   <= slot_next;
            fill_reg   <= fill_next;
            wsum_reg   <= wsum_next;
            mvalid_reg <= mvalid_next;
        end
        mean_reg  <= mean_next;
        level_reg <= level_next;
        pct_reg   <= pct_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

>>> src/tmma_checker.sv
module tmma_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tmma_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result transaction holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // percent never exceeds full scale
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:24] <= 7'd100)
        else $error("level percent out of range");

    // input side closes only right after taking a sample
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("s_tready dropped without a transaction");

    // no result shows up in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // percent matches the filtered level
    a_pct_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[30:24]) == (32'(m_tdata[23:12]) * 32'd100) / 32'd4095)
        else $error("level percent does not match filtered level");

endmodule

bind trimmed_mean_moving_average_core tmma_checker u_tmma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
